// File: sv/slotted_page_row_store_assert.svh
// assertion macros used by the slotted page row store sequencer
// expects aclk and aresetn in the scope of each use
`ifndef SLOTTED_PAGE_ROW_STORE_ASSERT_SVH
`define SLOTTED_PAGE_ROW_STORE_ASSERT_SVH

// condition holds at every edge out of reset
`define SPR_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SPR_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/spr_pkg.sv
// types, codes and constants of the slotted page row store
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

    localparam int PAGE_WORDS  = 1024;
    localparam int ADDR_W      = $clog2(PAGE_WORDS);
    localparam int MAX_ROW_LEN = 64;
    localparam int LEN_W       = 7;
    localparam int SUM_W       = ADDR_W + 1;
    localparam int WORD_W      = 16;

    // input item kinds
    localparam logic [1:0] KIND_INS_START = 2'd0;
    localparam logic [1:0] KIND_INS_DATA  = 2'd1;
    localparam logic [1:0] KIND_GET       = 2'd2;
    localparam logic [1:0] KIND_DELETE    = 2'd3;

    // result kinds
    localparam logic [1:0] RK_INSERT = 2'd0;
    localparam logic [1:0] RK_BYTE   = 2'd1;
    localparam logic [1:0] RK_DELETE = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_SPACE  = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LEN_W-1:0] row_len;
        logic [7:0]       data_byte;
        logic [9:0]       row_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [2:0] status;
        logic [9:0] slot_index;
        logic [7:0] out_byte;
        logic       last;
    } out_item_t;

    function automatic out_item_t make_res(logic [1:0] rk, logic [2:0] st,
                                           logic [9:0] slot, logic [7:0] b,
                                           logic lst);
        out_item_t r;
        r.result_kind = rk;
        r.status      = st;
        r.slot_index  = slot;
        r.out_byte    = b;
        r.last        = lst;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/spr_ram.sv
// page word memory, one write port and one registered read port
// depends on spr_pkg
`timescale 1ns / 1ps
`default_nettype none

module spr_ram
    import spr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WORD_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [PAGE_WORDS];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/spr_out.sv
// result output register between the sequencer and the result channel
// depends on spr_pkg
`timescale 1ns / 1ps
`default_nettype none

module spr_out
    import spr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      res_valid,
    output logic           res_ready,
    input  wire out_item_t res_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    logic      valid_reg;
    out_item_t item_reg;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_item    = item_reg;

    // load on handshake, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            item_reg <= res_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/spr_ctrl.sv
// sequencer: insert, get, delete and the reset clearing pass over the page memory
// depends on spr_pkg, spr_ram and slotted_page_row_store_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "slotted_page_row_store_assert.svh"

module spr_ctrl
    import spr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           res_valid,
    input  wire logic      res_ready,
    output out_item_t      res_item
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_COMMIT, S_WALK, S_LAST, S_GET_RD, S_GET_DATA,
        S_EMIT, S_SH_RD, S_SH_WR, S_FREE
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]   used_reg, used_next;
    logic               ins_pending_reg, ins_pending_next;
    logic [ADDR_W-1:0]  ins_addr_reg, ins_addr_next;
    logic [LEN_W-1:0]   ins_rem_reg, ins_rem_next;
    logic [LEN_W-1:0]   ins_len_reg, ins_len_next;
    logic               op_del_reg, op_del_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0]  k_reg, k_next;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;
    logic [ADDR_W-1:0]  low_reg, low_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   i_reg, i_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic               more_reg, more_next;
    out_item_t          res_reg, res_next;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [WORD_W-1:0] wdata, rdata;

    logic [LEN_W-1:0] len_rd;
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] used_after;
    logic [SUM_W-1:0] top_a;
    logic [SUM_W-1:0] low_a;
    logic [SUM_W:0]   need;

    spr_ram u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res_item  = res_reg;

    // shared arithmetic for the walk end and the insert check
    assign len_rd     = rdata[LEN_W-1:0];
    assign total      = sum_reg + SUM_W'(len_rd);
    assign used_after = used_reg - SUM_W'(len_rd);
    assign top_a      = SUM_W'(PAGE_WORDS) - total - SUM_W'(1);
    assign low_a      = SUM_W'(PAGE_WORDS) - used_reg;
    assign need       = (SUM_W+1)'(used_reg) + (SUM_W+1)'(s_item.row_len)
                      + (SUM_W+1)'(2) + (SUM_W+1)'(count_reg);

    // next state logic
    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        used_next        = used_reg;
        ins_pending_next = ins_pending_reg;
        ins_addr_next    = ins_addr_reg;
        ins_rem_next     = ins_rem_reg;
        ins_len_next     = ins_len_reg;
        op_del_next      = op_del_reg;
        idx_next         = idx_reg;
        k_next           = k_reg;
        ptr_next         = ptr_reg;
        low_next         = low_reg;
        len_next         = len_reg;
        i_next           = i_reg;
        sum_next         = sum_reg;
        more_next        = more_reg;
        res_next         = res_reg;
        we               = 1'b0;
        waddr            = ptr_reg;
        wdata            = '0;
        raddr            = k_reg;

        case (state_reg)
            // zero the whole page after reset
            S_CLEAR: begin
                we       = 1'b1;
                ptr_next = ptr_reg + ADDR_W'(1);
                if (ptr_reg == ADDR_W'(PAGE_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    case (s_item.kind)
                        KIND_INS_START: begin
                            ins_pending_next = 1'b0;
                            ins_rem_next     = '0;
                            more_next        = 1'b0;
                            state_next       = S_EMIT;
                            if (s_item.row_len > LEN_W'(MAX_ROW_LEN)) begin
                                res_next = make_res(RK_INSERT, ST_TOO_LONG, '0, '0, 1'b1);
                            end else if (need > (SUM_W+1)'(PAGE_WORDS)) begin
                                res_next = make_res(RK_INSERT, ST_NO_SPACE, '0, '0, 1'b1);
                            end else begin
                                res_next = make_res(RK_INSERT, ST_OK, count_reg, '0, 1'b1);
                                ins_len_next  = s_item.row_len;
                                ins_rem_next  = s_item.row_len;
                                ins_addr_next = ADDR_W'(SUM_W'(PAGE_WORDS) - used_reg
                                                - SUM_W'(s_item.row_len));
                                ins_pending_next = 1'b1;
                                // empty row commits at once
                                if (s_item.row_len == '0) begin
                                    we               = 1'b1;
                                    waddr            = count_reg + ADDR_W'(1);
                                    count_next       = count_reg + ADDR_W'(1);
                                    ins_pending_next = 1'b0;
                                end
                            end
                        end
                        KIND_INS_DATA: begin
                            if (ins_pending_reg) begin
                                we            = 1'b1;
                                waddr         = ins_addr_reg;
                                wdata         = WORD_W'(s_item.data_byte);
                                ins_addr_next = ins_addr_reg + ADDR_W'(1);
                                ins_rem_next  = ins_rem_reg - LEN_W'(1);
                                if (ins_rem_reg == LEN_W'(1)) begin
                                    state_next = S_COMMIT;
                                end
                            end
                        end
                        default: begin
                            // get or delete
                            op_del_next = (s_item.kind == KIND_DELETE);
                            if (s_item.kind == KIND_DELETE) begin
                                ins_pending_next = 1'b0;
                                ins_rem_next     = '0;
                            end
                            idx_next  = s_item.row_index;
                            more_next = 1'b0;
                            if (s_item.row_index >= count_reg) begin
                                res_next = make_res((s_item.kind == KIND_DELETE) ?
                                                    RK_DELETE : RK_BYTE,
                                                    ST_BAD_INDEX, '0, '0, 1'b1);
                                state_next = S_EMIT;
                            end else begin
                                k_next     = ADDR_W'(1);
                                sum_next   = '0;
                                state_next = S_WALK;
                            end
                        end
                    endcase
                end
            end

            // write the length slot and bump the count
            S_COMMIT: begin
                we               = 1'b1;
                waddr            = count_reg + ADDR_W'(1);
                wdata            = WORD_W'(ins_len_reg);
                count_next       = count_reg + ADDR_W'(1);
                used_next        = used_reg + SUM_W'(ins_len_reg);
                ins_pending_next = 1'b0;
                ins_rem_next     = '0;
                state_next       = S_IDLE;
            end

            // sum the length slots up to the addressed row, one read a cycle
            S_WALK: begin
                raddr = k_reg;
                if (k_reg != ADDR_W'(1)) begin
                    sum_next = sum_reg + SUM_W'(len_rd);
                end
                if (k_reg == idx_reg + ADDR_W'(1)) begin
                    state_next = S_LAST;
                end else begin
                    k_next = k_reg + ADDR_W'(1);
                end
            end

            // last slot read is the row's own length
            S_LAST: begin
                if (len_rd == '0) begin
                    res_next   = make_res(op_del_reg ? RK_DELETE : RK_BYTE, ST_EMPTY,
                                          '0, '0, 1'b1);
                    state_next = S_EMIT;
                end else if (!op_del_reg) begin
                    len_next   = (len_rd > LEN_W'(MAX_ROW_LEN)) ? LEN_W'(MAX_ROW_LEN) : len_rd;
                    ptr_next   = ADDR_W'(SUM_W'(PAGE_WORDS) - total);
                    i_next     = '0;
                    state_next = S_GET_RD;
                end else begin
                    we        = 1'b1;
                    waddr     = idx_reg + ADDR_W'(1);
                    len_next  = len_rd;
                    used_next = used_after;
                    low_next  = ADDR_W'(low_a);
                    i_next    = '0;
                    if (top_a >= low_a) begin
                        ptr_next   = ADDR_W'(top_a);
                        state_next = S_SH_RD;
                    end else begin
                        ptr_next   = ADDR_W'(low_a);
                        state_next = S_FREE;
                    end
                end
            end

            S_GET_RD: begin
                raddr      = ptr_reg;
                state_next = S_GET_DATA;
            end

            S_GET_DATA: begin
                res_next   = make_res(RK_BYTE, ST_OK, '0, rdata[7:0],
                                      (i_reg + LEN_W'(1)) == len_reg);
                more_next  = (i_reg + LEN_W'(1)) != len_reg;
                ptr_next   = ptr_reg + ADDR_W'(1);
                i_next     = i_reg + LEN_W'(1);
                state_next = S_EMIT;
            end

            // hand the result to the output register
            S_EMIT: begin
                if (res_ready) begin
                    state_next = more_reg ? S_GET_RD : S_IDLE;
                end
            end

            // move lower rows up by the deleted length, top word first
            S_SH_RD: begin
                raddr      = ptr_reg;
                state_next = S_SH_WR;
            end

            S_SH_WR: begin
                we    = 1'b1;
                waddr = ptr_reg + ADDR_W'(len_reg);
                wdata = rdata;
                if (ptr_reg == low_reg) begin
                    i_next     = '0;
                    state_next = S_FREE;
                end else begin
                    ptr_next   = ptr_reg - ADDR_W'(1);
                    state_next = S_SH_RD;
                end
            end

            // clear the freed words at the bottom of the data area
            S_FREE: begin
                we       = 1'b1;
                ptr_next = ptr_reg + ADDR_W'(1);
                i_next   = i_reg + LEN_W'(1);
                if ((i_reg + LEN_W'(1)) == len_reg) begin
                    res_next   = make_res(RK_DELETE, ST_OK, '0, '0, 1'b1);
                    more_next  = 1'b0;
                    state_next = S_EMIT;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            count_reg       <= '0;
            used_reg        <= '0;
            ins_pending_reg <= 1'b0;
            ins_addr_reg    <= '0;
            ins_rem_reg     <= '0;
            ins_len_reg     <= '0;
            ptr_reg         <= '0;
            more_reg        <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            used_reg        <= used_next;
            ins_pending_reg <= ins_pending_next;
            ins_addr_reg    <= ins_addr_next;
            ins_rem_reg     <= ins_rem_next;
            ins_len_reg     <= ins_len_next;
            ptr_reg         <= ptr_next;
            more_reg        <= more_next;
        end
        op_del_reg <= op_del_next;
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        low_reg    <= low_next;
        len_reg    <= len_next;
        i_reg      <= i_next;
        sum_reg    <= sum_next;
        res_reg    <= res_next;
    end

    // bytes still to come always land above the slot area
    `SPR_ASSERT_IMPLIES(a_pending_above_slots, ins_pending_reg && (ins_rem_reg != '0),
        ins_addr_reg > (count_reg + ADDR_W'(1)), "pending insert overlaps the slot area")
    `SPR_ASSERT_HOLDS(a_page_budget,
        ((SUM_W+1)'(used_reg) + (SUM_W+1)'(count_reg)) <= (SUM_W+1)'(PAGE_WORDS),
        "rows and slots exceed the page")
    `SPR_ASSERT_IMPLIES(a_no_word0_write, we && (state_reg != S_CLEAR),
        waddr != '0, "write to the count word")

endmodule

`default_nettype wire

// File: sv/slotted_page_row_store.sv
// slotted page row store, top level
// depends on spr_pkg, spr_ctrl and spr_out
//
// channel   dir  handshake           payload
// s_        in   s_valid / s_ready   s_item (in_item_t)
// m_        out  m_valid / m_ready   m_item (out_item_t)
//
// after reset the page memory is zeroed, s_ready stays low meanwhile
// an insert start passes through the result state; the last data byte adds a commit
// get walks the length slots up to the row, then reads, loads and emits each row byte
// delete walks the same slots, then reads and writes each moved word and clears each freed word
// the single page memory read port paces every walk; results wait in an output register
`timescale 1ns / 1ps
`default_nettype none

module slotted_page_row_store
    import spr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    logic      res_valid;
    logic      res_ready;
    out_item_t res_item;

    // sequencer with the page memory
    spr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    // result register
    spr_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire
